### rtl/core/gbnms_pkg.sv
package gbnms_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned AreaW  = 2 * CoordW;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned ItemW  = ScoreW + 4 * CoordW;

  localparam logic [ThrW-1:0] ThrReset = 16'd32768;

  // stored box geometry, left in the low bits
  typedef struct packed {
    logic [CoordW-1:0] height;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } geom_t;

endpackage

### rtl/core/greedy_box_nms_unit.sv
// Greedy non-maximum suppression over up to MAX_BOXES scored boxes. Boxes are
// loaded one item per cycle into on-chip memories; an item with tlast set ends
// the set (boxes past capacity are dropped and every result of that set then
// carries the overflow flag in tuser). After the last item the unit stops
// taking input and works on the set in place: a rank pass orders the boxes by
// score, then area, then load order; the suppression pass walks that order and
// tests each later live box against every surviving box; the emit pass sends
// the survivors and waits on output stalls. The single read port of each
// memory paces all three passes. Survivors leave in order, tlast on the last
// one. The overlap threshold (unsigned Q0.16, reset 0x8000) is to be written
// only while the unit is idle; the block itself does not enforce this. A pair
// is suppressed when inter*65536 > threshold*union.
module greedy_box_nms_unit #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbnms_pkg::ThrW-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // score, left, top, box_width, box_height (from bit 0)
  input  logic [gbnms_pkg::ItemW-1:0] s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,   // final_box
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // kept_score, kept_left, kept_top, kept_width, kept_height (from bit 0)
  output logic [gbnms_pkg::ItemW-1:0] m_axis_tdata_o,
  output logic                        m_axis_tlast_o,   // run_end
  output logic                        m_axis_tuser_o    // overflowed
);

  localparam int unsigned IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned SpanW = gbnms_pkg::CoordW + 1;
  localparam int unsigned InterW = 2 * SpanW;
  localparam int unsigned UniW = gbnms_pkg::AreaW + 1;
  localparam int unsigned ProdW = gbnms_pkg::ThrW + UniW;
  localparam int unsigned CmpW = InterW + gbnms_pkg::ThrW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_BOXES);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SRD    = 5'd1;
  localparam logic [4:0] ST_SCUR   = 5'd2;
  localparam logic [4:0] ST_SJRD   = 5'd3;
  localparam logic [4:0] ST_SJCMP  = 5'd4;
  localparam logic [4:0] ST_SWR    = 5'd5;
  localparam logic [4:0] ST_POR    = 5'd6;
  localparam logic [4:0] ST_PKI    = 5'd7;
  localparam logic [4:0] ST_PGI    = 5'd8;
  localparam logic [4:0] ST_PGCAP  = 5'd9;
  localparam logic [4:0] ST_PJOR   = 5'd10;
  localparam logic [4:0] ST_PJK    = 5'd11;
  localparam logic [4:0] ST_PJG    = 5'd12;
  localparam logic [4:0] ST_PSPAN  = 5'd13;
  localparam logic [4:0] ST_PMUL   = 5'd14;
  localparam logic [4:0] ST_PUNI   = 5'd15;
  localparam logic [4:0] ST_PTST   = 5'd16;
  localparam logic [4:0] ST_EOR    = 5'd17;
  localparam logic [4:0] ST_EK     = 5'd18;
  localparam logic [4:0] ST_EG     = 5'd19;
  localparam logic [4:0] ST_EOUT   = 5'd20;

  // box memories share one address; order memory has its own
  logic [gbnms_pkg::ScoreW-1:0] score_mem [MAX_BOXES];
  gbnms_pkg::geom_t             geom_mem  [MAX_BOXES];
  logic [gbnms_pkg::AreaW-1:0]  area_mem  [MAX_BOXES];
  logic [IW-1:0]                order_mem [MAX_BOXES];

  logic [gbnms_pkg::ScoreW-1:0] score_rd_q;
  gbnms_pkg::geom_t             geom_rd_q;
  logic [gbnms_pkg::AreaW-1:0]  area_rd_q;
  logic [IW-1:0]                order_rd_q;

  logic [IW-1:0] box_addr;
  logic [IW-1:0] ord_addr;
  logic          box_we;
  logic          ord_we;

  logic [4:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [MAX_BOXES-1:0] alive_q, alive_d;
  logic [gbnms_pkg::ThrW-1:0] thr_q;
  logic [CW-1:0]        i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [CW-1:0]        surv_q, surv_d, emit_q, emit_d;
  logic [IW-1:0]        ki_q, ki_d, kj_q, kj_d;

  // payload registers
  logic [gbnms_pkg::ScoreW-1:0] si_q, si_d;
  logic [gbnms_pkg::AreaW-1:0]  ai_q, ai_d, aj_q, aj_d;
  gbnms_pkg::geom_t             gi_q, gi_d;
  logic [SpanW-1:0]             sx_q, sx_d, sy_q, sy_d;
  logic [InterW-1:0]            inter_q, inter_d;
  logic [UniW-1:0]              uni_q, uni_d;

  logic                       out_valid_q, out_valid_d;
  logic [gbnms_pkg::ItemW-1:0] out_data_q, out_data_d;
  logic                       out_last_q, out_last_d, out_user_q, out_user_d;

  logic                 in_acc;
  logic                 out_free;
  logic                 load_out;
  gbnms_pkg::geom_t     in_geom;
  logic [gbnms_pkg::AreaW-1:0] in_area;
  logic                 goes_before;
  logic [SpanW-1:0]     ri, rj, bi, bj, lo_x, hi_x, lo_y, hi_y;
  logic [ProdW-1:0]     thr_prod;
  logic [CmpW-1:0]      inter_sh;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign in_geom = gbnms_pkg::geom_t'(s_axis_tdata_i[gbnms_pkg::ItemW-1:gbnms_pkg::ScoreW]);
  assign in_area = gbnms_pkg::AreaW'(in_geom.width * in_geom.height);

  // rank test: does box j come before the held box i
  always_comb begin
    if (score_rd_q != si_q) begin
      goes_before = $signed(score_rd_q) > $signed(si_q);
    end else if (area_rd_q != ai_q) begin
      goes_before = area_rd_q > ai_q;
    end else begin
      goes_before = j_q < i_q;
    end
  end

  // overlap spans, edges at 17 bits
  always_comb begin
    ri = SpanW'(gi_q.left) + SpanW'(gi_q.width);
    rj = SpanW'(geom_rd_q.left) + SpanW'(geom_rd_q.width);
    bi = SpanW'(gi_q.top) + SpanW'(gi_q.height);
    bj = SpanW'(geom_rd_q.top) + SpanW'(geom_rd_q.height);
    lo_x = (gi_q.left > geom_rd_q.left) ? SpanW'(gi_q.left) : SpanW'(geom_rd_q.left);
    lo_y = (gi_q.top > geom_rd_q.top) ? SpanW'(gi_q.top) : SpanW'(geom_rd_q.top);
    hi_x = (ri < rj) ? ri : rj;
    hi_y = (bi < bj) ? bi : bj;
  end

  assign thr_prod = ProdW'(thr_q * uni_q);
  assign inter_sh = {inter_q, {gbnms_pkg::ThrW{1'b0}}};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    alive_d   = alive_q;
    i_d       = i_q;
    j_d       = j_q;
    rank_d    = rank_q;
    surv_d    = surv_q;
    emit_d    = emit_q;
    ki_d      = ki_q;
    kj_d      = kj_q;
    si_d      = si_q;
    ai_d      = ai_q;
    aj_d      = aj_q;
    gi_d      = gi_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    inter_d   = inter_q;
    uni_d     = uni_q;
    box_addr  = i_q[IW-1:0];
    ord_addr  = i_q[IW-1:0];
    box_we    = 1'b0;
    ord_we    = 1'b0;
    load_out  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        box_addr = cnt_q[IW-1:0];
        if (in_acc) begin
          if (cnt_q < MaxCnt) begin
            box_we = 1'b1;
            alive_d[cnt_q[IW-1:0]] = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            i_d = '0;
            state_d = ST_SRD;
          end
        end
      end
      ST_SRD: begin
        state_d = ST_SCUR;
      end
      ST_SCUR: begin
        si_d = score_rd_q;
        ai_d = area_rd_q;
        j_d = '0;
        rank_d = '0;
        state_d = ST_SJRD;
      end
      ST_SJRD: begin
        box_addr = j_q[IW-1:0];
        state_d = ST_SJCMP;
      end
      ST_SJCMP: begin
        if (goes_before) rank_d = rank_q + 1'b1;
        j_d = j_q + 1'b1;
        state_d = (j_q + 1'b1 == cnt_q) ? ST_SWR : ST_SJRD;
      end
      ST_SWR: begin
        ord_we = 1'b1;
        ord_addr = rank_q[IW-1:0];
        if (i_q + 1'b1 == cnt_q) begin
          i_d = '0;
          surv_d = cnt_q;
          state_d = ST_POR;
        end else begin
          i_d = i_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_POR: begin
        state_d = ST_PKI;
      end
      ST_PKI: begin
        ki_d = order_rd_q;
        if (alive_q[order_rd_q]) begin
          state_d = ST_PGI;
        end else if (i_q + 1'b1 == cnt_q) begin
          i_d = '0;
          emit_d = '0;
          state_d = ST_EOR;
        end else begin
          i_d = i_q + 1'b1;
          state_d = ST_POR;
        end
      end
      ST_PGI: begin
        box_addr = ki_q;
        state_d = ST_PGCAP;
      end
      ST_PGCAP: begin
        gi_d = geom_rd_q;
        ai_d = area_rd_q;
        j_d = i_q + 1'b1;
        if (i_q + 1'b1 == cnt_q) begin
          i_d = '0;
          emit_d = '0;
          state_d = ST_EOR;
        end else begin
          state_d = ST_PJOR;
        end
      end
      ST_PJOR: begin
        ord_addr = j_q[IW-1:0];
        state_d = ST_PJK;
      end
      ST_PJK, ST_PTST: begin
        if (state_q == ST_PJK) begin
          kj_d = order_rd_q;
        end else if (inter_sh > CmpW'(thr_prod)) begin
          alive_d[kj_q] = 1'b0;
          surv_d = surv_q - 1'b1;
        end
        if (state_q == ST_PJK && alive_q[order_rd_q]) begin
          state_d = ST_PJG;
        end else if (j_q + 1'b1 != cnt_q) begin
          j_d = j_q + 1'b1;
          state_d = ST_PJOR;
        end else begin
          i_d = i_q + 1'b1;
          state_d = ST_POR;
        end
      end
      ST_PJG: begin
        box_addr = kj_q;
        state_d = ST_PSPAN;
      end
      ST_PSPAN: begin
        sx_d = (hi_x > lo_x) ? hi_x - lo_x : '0;
        sy_d = (hi_y > lo_y) ? hi_y - lo_y : '0;
        aj_d = area_rd_q;
        state_d = ST_PMUL;
      end
      ST_PMUL: begin
        inter_d = InterW'(sx_q * sy_q);
        state_d = ST_PUNI;
      end
      ST_PUNI: begin
        uni_d = UniW'(UniW'(ai_q) + UniW'(aj_q) - UniW'(inter_q));
        state_d = ST_PTST;
      end
      ST_EOR: begin
        state_d = ST_EK;
      end
      ST_EK, ST_EOUT: begin
        // keep the survivor's words on the read port while output stalls
        if (state_q == ST_EOUT) box_addr = ki_q;
        if (state_q == ST_EK) ki_d = order_rd_q;
        if (state_q == ST_EK && alive_q[order_rd_q]) begin
          state_d = ST_EG;
        end else if (state_q == ST_EOUT && !out_free) begin
          state_d = ST_EOUT;
        end else begin
          if (state_q == ST_EOUT) begin
            load_out = 1'b1;
            emit_d = emit_q + 1'b1;
          end
          if (i_q + 1'b1 == cnt_q) begin
            cnt_d = '0;
            alive_d = '0;
            ovf_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
            state_d = ST_EOR;
          end
        end
      end
      ST_EG: begin
        box_addr = ki_q;
        state_d = ST_EOUT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {geom_rd_q, score_rd_q};
      out_last_d  = (emit_q + 1'b1 == surv_q);
      out_user_d  = ovf_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      score_mem[box_addr] <= s_axis_tdata_i[gbnms_pkg::ScoreW-1:0];
      geom_mem[box_addr]  <= in_geom;
      area_mem[box_addr]  <= in_area;
    end
    score_rd_q <= score_mem[box_addr];
    geom_rd_q  <= geom_mem[box_addr];
    area_rd_q  <= area_mem[box_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) order_mem[ord_addr] <= i_q[IW-1:0];
    order_rd_q <= order_mem[ord_addr];
  end

  always_ff @(posedge clk_i) begin
    si_d_reg: begin
      si_q    <= si_d;
      ai_q    <= ai_d;
      aj_q    <= aj_d;
      gi_q    <= gi_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      inter_q <= inter_d;
      uni_q   <= uni_d;
      ki_q    <= ki_d;
      kj_q    <= kj_d;
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
      out_user_q <= out_user_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      alive_q     <= '0;
      thr_q       <= gbnms_pkg::ThrReset;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      surv_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      alive_q     <= alive_d;
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      i_q         <= i_d;
      j_q         <= j_d;
      rank_q      <= rank_d;
      surv_q      <= surv_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("box count past capacity");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> emit_q < surv_q)
    else $error("more survivors emitted than counted");

  a_final_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast_i) |=> (state_q == ST_SRD))
    else $error("final item did not start processing");

  a_emit_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> alive_q[ki_q])
    else $error("suppressed box emitted");

endmodule

### sim/greedy_box_nms_unit_checker.sv
`timescale 1ns / 1ps

module greedy_box_nms_unit_checker #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbnms_pkg::ThrW-1:0]  cfg_wdata_i,
  input  logic                        s_axis_tvalid_i,
  input  logic                        s_axis_tready_o,
  input  logic [gbnms_pkg::ItemW-1:0] s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  input  logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  input  logic [gbnms_pkg::ItemW-1:0] m_axis_tdata_o,
  input  logic                        m_axis_tlast_o,
  input  logic                        m_axis_tuser_o,
  output int                          errors_o,
  output int                          pending_o,
  output int                          kept_seen_o
);

  typedef struct packed {
    logic                        ovf;
    logic                        last;
    logic [gbnms_pkg::ItemW-1:0] data;
  } kept_t;

  logic [gbnms_pkg::ScoreW-1:0] score_mem [MAX_BOXES];
  gbnms_pkg::geom_t             geom_mem  [MAX_BOXES];
  int unsigned                  n_boxes;
  logic                         dropped;
  logic [gbnms_pkg::ThrW-1:0]   thr;
  kept_t                        kept_q [$];

  function automatic logic [gbnms_pkg::AreaW-1:0] area(gbnms_pkg::geom_t g);
    return g.width * g.height;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    if (score_mem[a] != score_mem[b])
      return $signed(score_mem[a]) > $signed(score_mem[b]);
    return area(geom_mem[a]) > area(geom_mem[b]);
  endfunction

  function automatic logic [16:0] span(logic [16:0] a0, a1, b0, b1);
    logic [16:0] lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 17'd0;
  endfunction

  function automatic bit too_close(gbnms_pkg::geom_t g, gbnms_pkg::geom_t h);
    logic [63:0] inter, uni;
    inter = span(g.left, g.left + 17'(g.width), h.left, h.left + 17'(h.width))
          * span(g.top, g.top + 17'(g.height), h.top, h.top + 17'(h.height));
    uni = 64'(area(g)) + 64'(area(h)) - inter;
    return (inter << 16) > 64'(thr) * uni;
  endfunction

  // sort, suppress, queue the survivors of a set of n boxes
  task automatic predict_survivors(int unsigned n, logic dr);
    int order [$];
    bit alive [MAX_BOXES];
    int j, lastpos;
    kept_t k;
    for (int i = 0; i < n; i++) begin
      j = order.size();
      while (j > 0 && ranks_ahead(i, order[j-1])) j--;
      order.insert(j, i);
      alive[i] = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (!alive[order[i]]) continue;
      for (int m = i + 1; m < n; m++)
        if (alive[order[m]] && too_close(geom_mem[order[i]], geom_mem[order[m]]))
          alive[order[m]] = 1'b0;
    end
    lastpos = -1;
    for (int i = 0; i < n; i++) if (alive[order[i]]) lastpos = i;
    for (int i = 0; i < n; i++) begin
      if (!alive[order[i]]) continue;
      k.data = {geom_mem[order[i]], score_mem[order[i]]};
      k.last = (i == lastpos);
      k.ovf  = dr;
      kept_q.insert(kept_q.size(), k);
    end
  endtask

  assign pending_o = kept_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t exp_k;
    if (!rst_ni) begin
      n_boxes     <= 0;
      dropped     <= 1'b0;
      thr         = gbnms_pkg::ThrReset;
      errors_o    <= 0;
      kept_seen_o <= 0;
      kept_q.delete();
    end else begin
      if (cfg_we_i) thr = cfg_wdata_i;
      // output side first: survivors of a set can't leave in the cycle it ends
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        kept_seen_o <= kept_seen_o + 1;
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected kept box %h last %b ovf %b", $time,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
          errors_o <= errors_o + 1;
        end else begin
          exp_k = kept_q.pop_front();
          if (exp_k.data !== m_axis_tdata_o || exp_k.last !== m_axis_tlast_o ||
              exp_k.ovf !== m_axis_tuser_o) begin
            $display("%0t: kept box mismatch exp %h/%b/%b got %h/%b/%b", $time,
                     exp_k.data, exp_k.last, exp_k.ovf,
                     m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        automatic int unsigned nb = n_boxes;
        automatic logic dr = dropped;
        if (nb < MAX_BOXES) begin
          score_mem[nb] = s_axis_tdata_i[gbnms_pkg::ScoreW-1:0];
          geom_mem[nb]  = s_axis_tdata_i[gbnms_pkg::ItemW-1:gbnms_pkg::ScoreW];
          nb++;
        end else dr = 1'b1;
        if (s_axis_tlast_i) begin
          predict_survivors(nb, dr);
          nb = 0;
          dr = 1'b0;
        end
        n_boxes <= nb;
        dropped <= dr;
      end
    end
  end
endmodule

### sim/greedy_box_nms_unit_tb.sv
`timescale 1ns / 1ps

module greedy_box_nms_unit_tb;

  localparam int unsigned MaxBoxes = 64;
  localparam int unsigned CycleLimit = 3_000_000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [gbnms_pkg::ThrW-1:0]  cfg_wdata_i = '0;
  logic                        s_valid = 1'b0;
  logic                        s_ready;
  logic [gbnms_pkg::ItemW-1:0] s_data = '0;   // score, left, top, width, height from bit 0
  logic                        s_last = 1'b0; // final box of the set
  logic                        m_valid;
  logic                        m_ready = 1'b0;
  logic [gbnms_pkg::ItemW-1:0] m_data;
  logic                        m_last;
  logic                        m_user;

  int errors, pending, kept_seen;
  int boxes_sent = 0, sets_sent = 0;
  int cycles = 0;
  bit hold_sink = 1'b0;   // long receiver hold-off requested by stimulus

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  greedy_box_nms_unit #(.MAX_BOXES(MaxBoxes)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last), .m_axis_tuser_o(m_user)
  );

  greedy_box_nms_unit_checker #(.MAX_BOXES(MaxBoxes)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tlast_o(m_last), .m_axis_tuser_o(m_user),
    .errors_o(errors), .pending_o(pending), .kept_seen_o(kept_seen)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d kept boxes outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: mode-switching stall pattern, plus a long hold when asked
  always @(posedge clk_i) begin
    int mode, left_in_mode;
    if (left_in_mode <= 0) begin
      mode = $urandom_range(0, 2);
      left_in_mode = $urandom_range(10, 80);
    end
    left_in_mode--;
    if (hold_sink) m_ready <= 1'b0;
    else case (mode)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // offer one item and wait for acceptance; random gap first when bursting
  task automatic send_box(logic [31:0] score, logic [15:0] l, logic [15:0] t,
                          logic [15:0] w, logic [15:0] h, logic fin, int gap);
    repeat (gap) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {h, w, t, l, score};
    s_last  <= fin;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    boxes_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic drain_and_idle();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [gbnms_pkg::ThrW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // a cluster-heavy set: boxes jittered around a few centers, random scores
  task automatic send_set(int n, bit bursty);
    logic [15:0] cx [4], cy [4];
    int c, gap, burst;
    burst = 0;
    for (int k = 0; k < 4; k++) begin
      cx[k] = 16'($urandom_range(0, 400));
      cy[k] = 16'($urandom_range(0, 400));
    end
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 3);
      if (bursty && burst == 0) begin
        burst = $urandom_range(1, 8);
        gap = $urandom_range(0, 6);
      end else gap = 0;
      if (burst > 0) burst--;
      if ($urandom_range(0, 9) == 0)
        // noise: full-range fields
        send_box($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 i == n - 1, gap);
      else
        send_box(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) << 16 : $urandom,
                 16'(cx[c] + $urandom_range(0, 12)), 16'(cy[c] + $urandom_range(0, 12)),
                 16'($urandom_range(8, 40)), 16'($urandom_range(8, 40)), i == n - 1, gap);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, equal scores by area, full ties, empty areas
    send_box(32'h7fff_ffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0, 0);
    send_box(32'h8000_0000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 0);
    send_box(32'h8000_0000, 16'd5, 16'd5, 16'd0, 16'd0, 1'b0, 0);
    send_box(32'h0001_0000, 16'd10, 16'd10, 16'd20, 16'd20, 1'b0, 0);
    send_box(32'h0001_0000, 16'd10, 16'd10, 16'd30, 16'd30, 1'b0, 0);
    send_box(32'h0001_0000, 16'd12, 16'd12, 16'd20, 16'd20, 1'b0, 0);
    send_box(32'h0001_0000, 16'd200, 16'd200, 16'd20, 16'd20, 1'b0, 0);
    send_box(32'hffff_0000, 16'hfff0, 16'd0, 16'hffff, 16'd1, 1'b1, 0);
    send_box(32'h1234_5678, 16'd1, 16'd2, 16'd3, 16'd4, 1'b1, 0);  // single box set
    drain_and_idle();
    write_threshold(16'd0);       // any overlap suppresses
    send_box(32'h10, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0, 0);
    send_box(32'h20, 16'd9, 16'd9, 16'd10, 16'd10, 1'b0, 0);
    send_box(32'h30, 16'd10, 16'd10, 16'd10, 16'd10, 1'b0, 0);
    send_box(32'h40, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 0);
    drain_and_idle();
    write_threshold(16'hffff);    // only near-identical boxes suppress
    send_box(32'h5, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0, 0);
    send_box(32'h5, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0, 0);
    send_box(32'h6, 16'd0, 16'd0, 16'd10, 16'd11, 1'b1, 0);
    drain_and_idle();

    // overflow: a full set plus extra boxes, with the receiver held off
    // past the end of processing so results back up and input stalls
    write_threshold(gbnms_pkg::ThrReset);
    send_set(MaxBoxes, 1'b0);     // ends a set at exactly capacity
    drain_and_idle();
    hold_sink = 1'b1;
    fork
      begin
        repeat (30000) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        send_set(MaxBoxes + 3, 1'b0);
        send_set(6, 1'b1);        // offered while results are backed up
      end
    join
    drain_and_idle();

    // random sets, threshold swept between sets
    while (boxes_sent < 225) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_and_idle();
        write_threshold(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) * 16'hffff)
                                                     : 16'($urandom));
      end
      send_set(($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10),
               1'b1);
    end
    drain_and_idle();
    repeat (200) @(posedge clk_i);

    $display("covered %0d boxes in %0d sets, %0d kept boxes checked, thresholds swept",
             boxes_sent, sets_sent, kept_seen);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
